/* hw/rtl/kcdl_pkg.sv */
// ----------------------------------------------------------------------------
// Keypad and card door lock: shared types and constants
// Item, result and register types, key and event codes, and the
// one-hot codes of the lock mode.
// ----------------------------------------------------------------------------
package kcdl_pkg;

	localparam int CMD_W     = 2;
	localparam int DIST_W    = 9;
	localparam int KEY_W     = 4;
	localparam int UID_W     = 32;
	localparam int TIMER_W   = 16;
	localparam int EVENT_W   = 3;
	localparam int SHOWN_W   = 4;
	localparam int LMODE_W   = 2;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 32;

	typedef logic [KEY_W-1:0] key_t;

	localparam logic [CMD_W-1:0] CMD_TICK   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_KEY    = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CARD   = 2'd2;
	localparam logic [CMD_W-1:0] CMD_REMOTE = 2'd3;

	localparam key_t KEY_MENU_EXIT = 4'd0;
	localparam key_t KEY_SET_ADMIN = 4'd1;
	localparam key_t KEY_SET_USER  = 4'd2;
	localparam key_t KEY_CLEAR     = 4'd14;
	localparam key_t KEY_ENTER     = 4'd15;

	localparam logic [CFG_IDX_W-1:0] CFG_OPEN_TICKS   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_TICKS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_NEAR_LIMIT   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CARD_UID     = 2'd3;

	localparam logic [TIMER_W-1:0] RST_OPEN_TICKS   = 16'd80;
	localparam logic [TIMER_W-1:0] RST_ACTIVE_TICKS = 16'd150;
	localparam logic [DIST_W-1:0]  RST_NEAR_LIMIT   = 9'd15;
	localparam logic [UID_W-1:0]   RST_CARD_UID     = 32'hCC6B_3702;

	localparam int   DEF_CODE_LEN = 4;
	localparam key_t DEF_USER_CODE  [DEF_CODE_LEN] = '{4'd1, 4'd2, 4'd3, 4'd4};
	localparam key_t DEF_ADMIN_CODE [DEF_CODE_LEN] = '{4'd4, 4'd3, 4'd2, 4'd1};

	typedef enum logic [EVENT_W-1:0] {
		EV_NONE        = 3'd0,
		EV_OPENED      = 3'd1,
		EV_CLOSED      = 3'd2,
		EV_WRONG_CODE  = 3'd3,
		EV_WRONG_CARD  = 3'd4,
		EV_WRONG_ADMIN = 3'd5,
		EV_CHANGED     = 3'd6
	} event_t;

	typedef enum logic [3:0] {
		M_NORMAL    = 4'b0001,
		M_ADMIN_TRY = 4'b0010,
		M_MENU      = 4'b0100,
		M_NEW_CODE  = 4'b1000
	} mode_t;

	typedef enum logic [1:0] {
		TGT_NONE  = 2'd0,
		TGT_ADMIN = 2'd1,
		TGT_USER  = 2'd2
	} target_t;

	localparam logic [LMODE_W-1:0] LM_NORMAL    = 2'd0;
	localparam logic [LMODE_W-1:0] LM_ADMIN_TRY = 2'd1;
	localparam logic [LMODE_W-1:0] LM_MENU      = 2'd2;
	localparam logic [LMODE_W-1:0] LM_NEW_CODE  = 2'd3;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [DIST_W-1:0] distance_cm;
		key_t              key_code;
		logic [UID_W-1:0]  card_uid;
		logic              remote_open;
	} item_t;

	typedef struct packed {
		logic                door_open;
		logic                lock_active;
		event_t              event_res;
		logic [SHOWN_W-1:0]  entered_keys;
		logic [LMODE_W-1:0]  lock_mode;
	} res_t;

	typedef struct packed {
		logic [TIMER_W-1:0] open_ticks;
		logic [TIMER_W-1:0] active_ticks;
		logic [DIST_W-1:0]  near_limit_cm;
		logic [UID_W-1:0]   valid_card_uid;
	} cfg_t;

endpackage

/* hw/rtl/kcdl_ifs.sv */
// ----------------------------------------------------------------------------
// Keypad and card door lock: channel interfaces
// Event items in, result items out, and the register write channel.
// ----------------------------------------------------------------------------
interface kcdl_evt_if import kcdl_pkg::*;;
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  cmd;
	logic [DIST_W-1:0] distance_cm;
	logic [KEY_W-1:0]  key_code;
	logic [UID_W-1:0]  card_uid;
	logic              remote_open;

	modport source(output valid, cmd, distance_cm, key_code, card_uid, remote_open,
		input ready);
	modport sink(input valid, cmd, distance_cm, key_code, card_uid, remote_open,
		output ready);
endinterface

interface kcdl_res_if import kcdl_pkg::*;;
	logic               valid;
	logic               ready;
	logic               door_open;
	logic               lock_active;
	logic [EVENT_W-1:0] event_res;
	logic [SHOWN_W-1:0] entered_keys;
	logic [LMODE_W-1:0] lock_mode;

	modport source(output valid, door_open, lock_active, event_res, entered_keys,
		lock_mode, input ready);
	modport sink(input valid, door_open, lock_active, event_res, entered_keys,
		lock_mode, output ready);
endinterface

interface kcdl_cfg_if import kcdl_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DAT_W-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

/* hw/rtl/kcdl_core.sv */
// ----------------------------------------------------------------------------
// Keypad and card door lock: lock state and event handling
// Holds the lock state and code stores and applies one event item per
// accepted cycle, producing the result item for that event.
// ----------------------------------------------------------------------------
module kcdl_core import kcdl_pkg::*; #(
	parameter int MAX_CODE = 8
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  accept,
	input  item_t item,
	input  cfg_t  cfg,
	output res_t  res
);

	localparam int IDX_W   = (MAX_CODE > 1) ? $clog2(MAX_CODE) : 1;
	localparam int CNT_W   = $clog2(MAX_CODE + 1);
	localparam int DEF_LEN = (MAX_CODE < DEF_CODE_LEN) ? MAX_CODE : DEF_CODE_LEN;

	mode_t              mode_q, n_mode;
	target_t            tgt_q, n_tgt;
	logic               door_q, n_door;
	logic               active_q, n_active;
	logic               hold_q, n_hold;
	logic [TIMER_W-1:0] active_left_q, n_active_left;
	logic [TIMER_W-1:0] open_left_q, n_open_left;
	logic [CNT_W-1:0]   pin_cnt_q, n_pin_cnt;
	logic [CNT_W-1:0]   aux_cnt_q, n_aux_cnt;
	logic [CNT_W-1:0]   user_len_q, n_user_len;
	logic [CNT_W-1:0]   admin_len_q, n_admin_len;
	key_t               pin_keys_q   [MAX_CODE];
	key_t               aux_keys_q   [MAX_CODE];
	key_t               user_code_q  [MAX_CODE];
	key_t               admin_code_q [MAX_CODE];

	logic               pin_we, aux_we, copy_user, copy_admin;
	logic               pin_ok, aux_ok, near;
	event_t             ev;
	logic [CNT_W-1:0]   shown;
	logic [CNT_W+3:0]   shown_ext;

	always_comb begin
		pin_ok = (pin_cnt_q == user_len_q);
		aux_ok = (aux_cnt_q == admin_len_q);
		for (int i = 0; i < MAX_CODE; i++) begin
			if (CNT_W'(i) < pin_cnt_q && pin_keys_q[i] != user_code_q[i]) begin
				pin_ok = 1'b0;
			end
			if (CNT_W'(i) < aux_cnt_q && aux_keys_q[i] != admin_code_q[i]) begin
				aux_ok = 1'b0;
			end
		end
	end

	assign near = (item.distance_cm != '0) && (item.distance_cm < cfg.near_limit_cm);

	always_comb begin
		n_mode        = mode_q;
		n_tgt         = tgt_q;
		n_door        = door_q;
		n_active      = active_q;
		n_hold        = hold_q;
		n_active_left = active_left_q;
		n_open_left   = open_left_q;
		n_pin_cnt     = pin_cnt_q;
		n_aux_cnt     = aux_cnt_q;
		n_user_len    = user_len_q;
		n_admin_len   = admin_len_q;
		pin_we        = 1'b0;
		aux_we        = 1'b0;
		copy_user     = 1'b0;
		copy_admin    = 1'b0;
		ev            = EV_NONE;

		unique case (item.cmd)
			CMD_TICK: begin
				if (near) begin
					n_active_left = cfg.active_ticks;
					n_active      = 1'b1;
				end else if (n_active_left != '0) begin
					n_active_left = n_active_left - 1'b1;
				end
				if (n_active && n_active_left == '0 && !n_door && !n_hold) begin
					n_active  = 1'b0;
					n_pin_cnt = '0;
					n_door    = 1'b0;
					n_hold    = 1'b0;
					n_mode    = M_NORMAL;
					n_aux_cnt = '0;
					n_tgt     = TGT_NONE;
				end
				if (n_open_left != '0) begin
					n_open_left = n_open_left - 1'b1;
				end
				if (n_door && n_open_left == '0 &&
						(n_mode == M_NORMAL || n_mode == M_ADMIN_TRY)) begin
					n_door    = 1'b0;
					n_hold    = 1'b0;
					n_mode    = M_NORMAL;
					n_aux_cnt = '0;
					n_tgt     = TGT_NONE;
					ev        = EV_CLOSED;
				end
			end
			CMD_KEY: begin
				unique case (mode_q)
					M_NORMAL: begin
						if (active_q) begin
							if (item.key_code == KEY_ENTER) begin
								n_pin_cnt = '0;
								n_aux_cnt = '0;
								n_tgt     = TGT_NONE;
								if (pin_ok) begin
									n_door      = 1'b1;
									n_open_left = cfg.open_ticks;
									n_mode      = M_ADMIN_TRY;
									ev          = EV_OPENED;
								end else begin
									n_door = 1'b0;
									n_hold = 1'b0;
									n_mode = M_NORMAL;
									ev     = EV_WRONG_CODE;
								end
							end else if (item.key_code == KEY_CLEAR) begin
								n_pin_cnt = '0;
							end else if (pin_cnt_q < CNT_W'(MAX_CODE)) begin
								pin_we    = 1'b1;
								n_pin_cnt = pin_cnt_q + 1'b1;
							end
						end
					end
					M_ADMIN_TRY: begin
						if (item.key_code == KEY_ENTER) begin
							n_aux_cnt = '0;
							if (aux_ok) begin
								n_mode = M_MENU;
							end else begin
								n_mode = M_NORMAL;
								ev     = EV_WRONG_ADMIN;
							end
						end else if (item.key_code == KEY_CLEAR) begin
							n_aux_cnt = '0;
						end else if (aux_cnt_q < CNT_W'(MAX_CODE)) begin
							aux_we    = 1'b1;
							n_aux_cnt = aux_cnt_q + 1'b1;
						end
					end
					M_MENU: begin
						if (item.key_code == KEY_MENU_EXIT) begin
							n_mode = M_NORMAL;
						end else begin
							n_tgt     = (item.key_code == KEY_SET_ADMIN) ? TGT_ADMIN :
								(item.key_code == KEY_SET_USER) ? TGT_USER : TGT_NONE;
							n_aux_cnt = '0;
							n_mode    = M_NEW_CODE;
						end
					end
					M_NEW_CODE: begin
						if (item.key_code == KEY_ENTER) begin
							if (tgt_q == TGT_ADMIN) begin
								copy_admin  = 1'b1;
								n_admin_len = aux_cnt_q;
							end else if (tgt_q == TGT_USER) begin
								copy_user  = 1'b1;
								n_user_len = aux_cnt_q;
							end
							n_aux_cnt = '0;
							n_tgt     = TGT_NONE;
							n_mode    = M_MENU;
							ev        = EV_CHANGED;
						end else if (item.key_code == KEY_CLEAR) begin
							n_aux_cnt = '0;
						end else if (aux_cnt_q < CNT_W'(MAX_CODE)) begin
							aux_we    = 1'b1;
							n_aux_cnt = aux_cnt_q + 1'b1;
						end
					end
					default: begin
						n_mode = M_NORMAL;
					end
				endcase
			end
			CMD_CARD: begin
				if (mode_q == M_NORMAL && active_q) begin
					n_aux_cnt = '0;
					n_tgt     = TGT_NONE;
					if (item.card_uid == cfg.valid_card_uid) begin
						n_door      = 1'b1;
						n_open_left = cfg.open_ticks;
						n_mode      = M_ADMIN_TRY;
						ev          = EV_OPENED;
					end else begin
						n_door = 1'b0;
						n_hold = 1'b0;
						n_mode = M_NORMAL;
						ev     = EV_WRONG_CARD;
					end
				end
			end
			CMD_REMOTE: begin
				n_aux_cnt = '0;
				n_tgt     = TGT_NONE;
				if (item.remote_open) begin
					n_hold      = 1'b1;
					n_active    = 1'b1;
					n_door      = 1'b1;
					n_open_left = cfg.open_ticks;
					n_mode      = M_ADMIN_TRY;
					ev          = EV_OPENED;
				end else begin
					n_door = 1'b0;
					n_hold = 1'b0;
					n_mode = M_NORMAL;
					ev     = EV_CLOSED;
				end
			end
		endcase
	end

	always_comb begin
		res = '0;
		unique case (n_mode)
			M_NORMAL: begin
				shown         = n_pin_cnt;
				res.lock_mode = LM_NORMAL;
			end
			M_ADMIN_TRY: begin
				shown         = n_aux_cnt;
				res.lock_mode = LM_ADMIN_TRY;
			end
			M_MENU: begin
				shown         = '0;
				res.lock_mode = LM_MENU;
			end
			M_NEW_CODE: begin
				shown         = n_aux_cnt;
				res.lock_mode = LM_NEW_CODE;
			end
			default: begin
				shown         = '0;
				res.lock_mode = LM_NORMAL;
			end
		endcase
		shown_ext        = {4'b0000, shown};
		res.door_open    = n_door;
		res.lock_active  = n_active;
		res.event_res    = ev;
		res.entered_keys = shown_ext[SHOWN_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= M_NORMAL;
			tgt_q         <= TGT_NONE;
			door_q        <= 1'b0;
			active_q      <= 1'b0;
			hold_q        <= 1'b0;
			active_left_q <= '0;
			open_left_q   <= '0;
			pin_cnt_q     <= '0;
			aux_cnt_q     <= '0;
			user_len_q    <= CNT_W'(DEF_LEN);
			admin_len_q   <= CNT_W'(DEF_LEN);
			for (int i = 0; i < MAX_CODE; i++) begin
				if (i < DEF_LEN) begin
					user_code_q[i]  <= DEF_USER_CODE[2'(i)];
					admin_code_q[i] <= DEF_ADMIN_CODE[2'(i)];
				end else begin
					user_code_q[i]  <= '0;
					admin_code_q[i] <= '0;
				end
			end
		end else if (accept) begin
			mode_q        <= n_mode;
			tgt_q         <= n_tgt;
			door_q        <= n_door;
			active_q      <= n_active;
			hold_q        <= n_hold;
			active_left_q <= n_active_left;
			open_left_q   <= n_open_left;
			pin_cnt_q     <= n_pin_cnt;
			aux_cnt_q     <= n_aux_cnt;
			user_len_q    <= n_user_len;
			admin_len_q   <= n_admin_len;
			if (copy_user) begin
				user_code_q <= aux_keys_q;
			end
			if (copy_admin) begin
				admin_code_q <= aux_keys_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && pin_we) begin
			pin_keys_q[pin_cnt_q[IDX_W-1:0]] <= item.key_code;
		end
		if (accept && aux_we) begin
			aux_keys_q[aux_cnt_q[IDX_W-1:0]] <= item.key_code;
		end
	end

endmodule

/* hw/rtl/kcdl_skid.sv */
// ----------------------------------------------------------------------------
// Keypad and card door lock: result output buffer
// Output register with one skid entry, so that an item may be accepted
// while the previous result still waits at the output.
// ----------------------------------------------------------------------------
module kcdl_skid import kcdl_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  res_t push_d,
	output logic full,
	output logic out_valid,
	input  logic out_ready,
	output res_t out_d
);

	logic out_v_q, skid_v_q;
	res_t out_q, skid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (out_ready || !out_v_q) begin
			out_v_q  <= skid_v_q || push;
			skid_v_q <= 1'b0;
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready || !out_v_q) begin
			out_q <= skid_v_q ? skid_q : push_d;
		end else if (push) begin
			skid_q <= push_d;
		end
	end

	assign full      = skid_v_q;
	assign out_valid = out_v_q;
	assign out_d     = out_q;

endmodule

/* hw/rtl/keypad_card_door_lock_controller.sv */
// ----------------------------------------------------------------------------
// Keypad and card door lock controller
// Event driven door lock: presence ticks, key presses, card reads and remote
// commands drive the door, the active window and the code change menu.
//
//   channel   role     handshake     item
//   evt       sink     valid/ready   cmd, distance_cm, key_code, card_uid,
//                                     remote_open
//   res       source   valid/ready   door_open, lock_active, event_res,
//                                     entered_keys, lock_mode
//   cfg       sink     valid/ready   index, data (register write)
//
// Every accepted event item yields one result item. The result and the new
// lock state are registered together; evt takes one item per cycle when ready.
// The result waits in an output register backed by one skid entry, and evt
// stalls only when both are full. All control state clears on arst_n; the
// key entry buffers need no reset. Register writes always complete at once.
// ----------------------------------------------------------------------------
module keypad_card_door_lock_controller import kcdl_pkg::*; #(
	parameter int MAX_CODE = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	kcdl_evt_if.sink     evt,
	kcdl_res_if.source   res,
	kcdl_cfg_if.sink     cfg
);

	cfg_t  cfg_q;
	item_t item;
	res_t  res_d;
	res_t  res_o;
	logic  accept;
	logic  skid_full;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.open_ticks     <= RST_OPEN_TICKS;
			cfg_q.active_ticks   <= RST_ACTIVE_TICKS;
			cfg_q.near_limit_cm  <= RST_NEAR_LIMIT;
			cfg_q.valid_card_uid <= RST_CARD_UID;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_OPEN_TICKS:   cfg_q.open_ticks     <= cfg.data[TIMER_W-1:0];
				CFG_ACTIVE_TICKS: cfg_q.active_ticks   <= cfg.data[TIMER_W-1:0];
				CFG_NEAR_LIMIT:   cfg_q.near_limit_cm  <= cfg.data[DIST_W-1:0];
				CFG_CARD_UID:     cfg_q.valid_card_uid <= cfg.data[UID_W-1:0];
			endcase
		end
	end

	assign item.cmd         = evt.cmd;
	assign item.distance_cm = evt.distance_cm;
	assign item.key_code    = evt.key_code;
	assign item.card_uid    = evt.card_uid;
	assign item.remote_open = evt.remote_open;

	assign evt.ready = !skid_full;
	assign accept    = evt.valid && evt.ready;

	kcdl_core #(
		.MAX_CODE (MAX_CODE)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (item),
		.cfg    (cfg_q),
		.res    (res_d)
	);

	kcdl_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_d    (res_d),
		.full      (skid_full),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.out_d     (res_o)
	);

	assign res.door_open    = res_o.door_open;
	assign res.lock_active  = res_o.lock_active;
	assign res.event_res    = res_o.event_res;
	assign res.entered_keys = res_o.entered_keys;
	assign res.lock_mode    = res_o.lock_mode;

	a_stall_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		!evt.ready |-> res.valid)
		else $error("Event channel stalled with no result waiting.");

	a_open_needs_active: assert property (@(posedge clk) disable iff (!arst_n)
		accept && res_d.door_open |-> res_d.lock_active)
		else $error("Door open while the lock is inactive.");

	a_menu_needs_open: assert property (@(posedge clk) disable iff (!arst_n)
		accept && res_d.lock_mode != LM_NORMAL |-> res_d.door_open)
		else $error("Admin mode entered with the door closed.");

	a_event_matches_door: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (res_d.event_res == EV_OPENED || res_d.event_res == EV_CLOSED)
		|-> res_d.door_open == (res_d.event_res == EV_OPENED))
		else $error("Open or close event disagrees with the door state.");

endmodule

/* tb/tb_keypad_card_door_lock_controller.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Keypad and card door lock controller: testbench
// A short table of directed events runs first. Random event sequences then
// follow under several register settings: presence ticks, code entries, admin
// menu walks, cards and remote commands. A model of the lock kept here
// predicts the results the table leaves open, and both channels idle at random.
// ----------------------------------------------------------------------------
module tb_keypad_card_door_lock_controller;
	import kcdl_pkg::*;

	localparam int CODE_MAX    = 8;
	localparam int IDLE_LIMIT  = 2000;
	localparam int PHASE_ITEMS = 260;
	localparam int PHASES      = 5;
	localparam int PLAN_LEN    = 28;

	typedef struct packed {
		item_t ev_in;
		logic  typed;
		res_t  want;
	} plan_row_t;

	localparam res_t RES_IDLE = '{1'b0, 1'b0, EV_NONE, 4'd0, LM_NORMAL};

	localparam plan_row_t DOOR_PLAN [PLAN_LEN] = '{
		'{'{CMD_KEY, 9'd0, 4'd5, 32'd0, 1'b0}, 1'b1, RES_IDLE},
		'{'{CMD_CARD, 9'd0, 4'd0, RST_CARD_UID, 1'b0}, 1'b1, RES_IDLE},
		'{'{CMD_TICK, 9'd0, 4'd0, 32'd0, 1'b0}, 1'b1, RES_IDLE},
		'{'{CMD_TICK, 9'd14, 4'd0, 32'd0, 1'b0}, 1'b1,
			'{1'b0, 1'b1, EV_NONE, 4'd0, LM_NORMAL}},
		'{'{CMD_TICK, 9'd511, 4'd15, 32'hFFFF_FFFF, 1'b1}, 1'b0, RES_IDLE},
		'{'{CMD_KEY, 9'd0, 4'd1, 32'd0, 1'b0}, 1'b0, RES_IDLE},
		'{'{CMD_KEY, 9'd0, 4'd2, 32'd0, 1'b0}, 1'b0, RES_IDLE},
		'{'{CMD_KEY, 9'd0, 4'd3, 32'd0, 1'b0}, 1'b0, RES_IDLE},
		'{'{CMD_KEY, 9'd0, 4'd4, 32'd0, 1'b0}, 1'b0, RES_IDLE},
		'{'{CMD_KEY, 9'd0, KEY_ENTER, 32'd0, 1'b0}, 1'b1,
			'{1'b1, 1'b1, EV_OPENED, 4'd0, LM_ADMIN_TRY}},
		'{'{CMD_KEY, 9'd0, 4'd4, 32'd0, 1'b0}, 1'b0, RES_IDLE},
		'{'{CMD_KEY, 9'd0, 4'd3, 32'd0, 1'b0}, 1'b0, RES_IDLE},
		'{'{CMD_KEY, 9'd0, 4'd2, 32'd0, 1'b0}, 1'b0, RES_IDLE},
		'{'{CMD_KEY, 9'd0, 4'd1, 32'd0, 1'b0}, 1'b0, RES_IDLE},
		'{'{CMD_KEY, 9'd0, KEY_ENTER, 32'd0, 1'b0}, 1'b0, RES_IDLE},
		'{'{CMD_KEY, 9'd0, KEY_SET_USER, 32'd0, 1'b0}, 1'b0, RES_IDLE},
		'{'{CMD_KEY, 9'd0, 4'd10, 32'd0, 1'b0}, 1'b0, RES_IDLE},
		'{'{CMD_KEY, 9'd0, KEY_ENTER, 32'd0, 1'b0}, 1'b1,
			'{1'b1, 1'b1, EV_CHANGED, 4'd0, LM_MENU}},
		'{'{CMD_KEY, 9'd0, KEY_MENU_EXIT, 32'd0, 1'b0}, 1'b0, RES_IDLE},
		'{'{CMD_REMOTE, 9'd0, 4'd0, 32'd0, 1'b0}, 1'b1,
			'{1'b0, 1'b1, EV_CLOSED, 4'd0, LM_NORMAL}},
		'{'{CMD_CARD, 9'd0, 4'd0, 32'd0, 1'b0}, 1'b1,
			'{1'b0, 1'b1, EV_WRONG_CARD, 4'd0, LM_NORMAL}},
		'{'{CMD_KEY, 9'd0, 4'd13, 32'd0, 1'b0}, 1'b0, RES_IDLE},
		'{'{CMD_KEY, 9'd0, KEY_CLEAR, 32'd0, 1'b0}, 1'b0, RES_IDLE},
		'{'{CMD_KEY, 9'd0, 4'd10, 32'd0, 1'b0}, 1'b0, RES_IDLE},
		'{'{CMD_KEY, 9'd0, KEY_ENTER, 32'd0, 1'b0}, 1'b1,
			'{1'b1, 1'b1, EV_OPENED, 4'd0, LM_ADMIN_TRY}},
		'{'{CMD_REMOTE, 9'd0, 4'd0, 32'd0, 1'b1}, 1'b1,
			'{1'b1, 1'b1, EV_OPENED, 4'd0, LM_ADMIN_TRY}},
		'{'{CMD_KEY, 9'd0, KEY_ENTER, 32'd0, 1'b0}, 1'b1,
			'{1'b1, 1'b1, EV_WRONG_ADMIN, 4'd0, LM_NORMAL}},
		'{'{CMD_KEY, 9'd0, KEY_ENTER, 32'd0, 1'b0}, 1'b1,
			'{1'b0, 1'b1, EV_WRONG_CODE, 4'd0, LM_NORMAL}}
	};

	logic clk;
	logic arst_n;

	kcdl_evt_if evt_ch ();
	kcdl_res_if res_ch ();
	kcdl_cfg_if cfg_ch ();

	keypad_card_door_lock_controller #(.MAX_CODE(CODE_MAX)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.evt    (evt_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	cfg_t               lock_cfg;
	logic [LMODE_W-1:0] p_mode;
	bit                 p_door;
	bit                 p_active;
	bit                 p_hold;
	logic [TIMER_W-1:0] p_active_left;
	logic [TIMER_W-1:0] p_open_left;
	key_t               p_pin [CODE_MAX];
	int                 p_pin_n;
	key_t               p_aux [CODE_MAX];
	int                 p_aux_n;
	target_t            p_target;
	key_t               p_user [CODE_MAX];
	int                 p_user_n;
	key_t               p_admin [CODE_MAX];
	int                 p_admin_n;

	res_t outcomes_due [$];
	int   bad_count   = 0;
	int   items_sent  = 0;
	int   quiet_cycles = 0;
	bit   tx_calm     = 1'b0;
	bit   rx_calm     = 1'b0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic void shut_door();
		p_door   = 1'b0;
		p_hold   = 1'b0;
		p_mode   = LM_NORMAL;
		p_aux_n  = 0;
		p_target = TGT_NONE;
	endfunction

	function automatic void swing_open();
		p_door      = 1'b1;
		p_open_left = lock_cfg.open_ticks;
		p_mode      = LM_ADMIN_TRY;
		p_aux_n     = 0;
		p_target    = TGT_NONE;
	endfunction

	function automatic bit entry_matches(bit vs_admin);
		bit ok;
		if (vs_admin) begin
			ok = (p_aux_n == p_admin_n);
			for (int i = 0; i < p_aux_n && ok; i++)
				if (p_aux[i] != p_admin[i])
					ok = 1'b0;
		end else begin
			ok = (p_pin_n == p_user_n);
			for (int i = 0; i < p_pin_n && ok; i++)
				if (p_pin[i] != p_user[i])
					ok = 1'b0;
		end
		return ok;
	endfunction

	function automatic event_t key_effect(key_t k);
		bit ok;
		case (p_mode)
			LM_NORMAL: begin
				if (!p_active)
					return EV_NONE;
				if (k == KEY_ENTER) begin
					ok = entry_matches(1'b0);
					p_pin_n = 0;
					if (ok) begin
						swing_open();
						return EV_OPENED;
					end
					shut_door();
					return EV_WRONG_CODE;
				end
				if (k == KEY_CLEAR) begin
					p_pin_n = 0;
				end else if (p_pin_n < CODE_MAX) begin
					p_pin[p_pin_n] = k;
					p_pin_n++;
				end
			end
			LM_ADMIN_TRY: begin
				if (k == KEY_ENTER) begin
					ok = entry_matches(1'b1);
					p_aux_n = 0;
					if (ok) begin
						p_mode = LM_MENU;
						return EV_NONE;
					end
					p_mode = LM_NORMAL;
					return EV_WRONG_ADMIN;
				end
				if (k == KEY_CLEAR) begin
					p_aux_n = 0;
				end else if (p_aux_n < CODE_MAX) begin
					p_aux[p_aux_n] = k;
					p_aux_n++;
				end
			end
			LM_MENU: begin
				if (k == KEY_MENU_EXIT) begin
					p_mode = LM_NORMAL;
					return EV_NONE;
				end
				p_target = (k == KEY_SET_ADMIN) ? TGT_ADMIN :
					(k == KEY_SET_USER) ? TGT_USER : TGT_NONE;
				p_aux_n = 0;
				p_mode  = LM_NEW_CODE;
			end
			default: begin
				if (k == KEY_ENTER) begin
					if (p_target == TGT_ADMIN) begin
						for (int i = 0; i < p_aux_n; i++)
							p_admin[i] = p_aux[i];
						p_admin_n = p_aux_n;
					end else if (p_target == TGT_USER) begin
						for (int i = 0; i < p_aux_n; i++)
							p_user[i] = p_aux[i];
						p_user_n = p_aux_n;
					end
					p_aux_n  = 0;
					p_target = TGT_NONE;
					p_mode   = LM_MENU;
					return EV_CHANGED;
				end
				if (k == KEY_CLEAR) begin
					p_aux_n = 0;
				end else if (p_aux_n < CODE_MAX) begin
					p_aux[p_aux_n] = k;
					p_aux_n++;
				end
			end
		endcase
		return EV_NONE;
	endfunction

	function automatic res_t next_lock_outcome(item_t it);
		event_t ev;
		res_t   r;
		ev = EV_NONE;
		case (it.cmd)
			CMD_TICK: begin
				if (it.distance_cm != 0 && it.distance_cm < lock_cfg.near_limit_cm) begin
					p_active_left = lock_cfg.active_ticks;
					p_active      = 1'b1;
				end else if (p_active_left != 0) begin
					p_active_left--;
				end
				if (p_active && p_active_left == 0 && !p_door && !p_hold) begin
					p_active = 1'b0;
					p_pin_n  = 0;
					shut_door();
				end
				if (p_open_left != 0)
					p_open_left--;
				if (p_door && p_open_left == 0 &&
						(p_mode == LM_NORMAL || p_mode == LM_ADMIN_TRY)) begin
					shut_door();
					ev = EV_CLOSED;
				end
			end
			CMD_KEY: begin
				ev = key_effect(it.key_code);
			end
			CMD_CARD: begin
				if (p_mode == LM_NORMAL && p_active) begin
					if (it.card_uid == lock_cfg.valid_card_uid) begin
						swing_open();
						ev = EV_OPENED;
					end else begin
						shut_door();
						ev = EV_WRONG_CARD;
					end
				end
			end
			default: begin
				if (it.remote_open) begin
					p_hold   = 1'b1;
					p_active = 1'b1;
					swing_open();
					ev = EV_OPENED;
				end else begin
					shut_door();
					ev = EV_CLOSED;
				end
			end
		endcase
		r.door_open   = p_door;
		r.lock_active = p_active;
		r.event_res   = ev;
		r.lock_mode   = p_mode;
		if (p_mode == LM_NORMAL)
			r.entered_keys = SHOWN_W'(p_pin_n);
		else if (p_mode == LM_MENU)
			r.entered_keys = '0;
		else
			r.entered_keys = SHOWN_W'(p_aux_n);
		return r;
	endfunction

	function automatic item_t any_item(logic [CMD_W-1:0] c);
		item_t it;
		it.cmd         = c;
		it.distance_cm = DIST_W'($urandom_range(0, 511));
		it.key_code    = key_t'($urandom_range(0, 15));
		it.card_uid    = $urandom;
		it.remote_open = 1'($urandom_range(0, 1));
		return it;
	endfunction

	task automatic send_event(input item_t it, input bit typed, input res_t want);
		int   gap;
		res_t foreseen;
		gap = tx_calm ? 0 : $urandom_range(0, 19);
		if (gap != 0) begin
			evt_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		evt_ch.cmd         = it.cmd;
		evt_ch.distance_cm = it.distance_cm;
		evt_ch.key_code    = it.key_code;
		evt_ch.card_uid    = it.card_uid;
		evt_ch.remote_open = it.remote_open;
		evt_ch.valid       = 1'b1;
		do @(posedge clk); while (!evt_ch.ready);
		foreseen = next_lock_outcome(it);
		outcomes_due.push_back(typed ? want : foreseen);
		items_sent++;
		@(negedge clk);
		if ($urandom_range(0, 63) == 0)
			tx_calm = !tx_calm;
	endtask

	task automatic send(input item_t it);
		send_event(it, 1'b0, RES_IDLE);
	endtask

	task automatic tap(input key_t k);
		item_t it;
		it          = any_item(CMD_KEY);
		it.key_code = k;
		send(it);
	endtask

	task automatic drain();
		evt_ch.valid = 1'b0;
		while (outcomes_due.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
		cfg_ch.index = idx;
		cfg_ch.data  = val;
		cfg_ch.valid = 1'b1;
		do @(posedge clk); while (!cfg_ch.ready);
		case (idx)
			CFG_OPEN_TICKS:   lock_cfg.open_ticks     = val[TIMER_W-1:0];
			CFG_ACTIVE_TICKS: lock_cfg.active_ticks   = val[TIMER_W-1:0];
			CFG_NEAR_LIMIT:   lock_cfg.near_limit_cm  = val[DIST_W-1:0];
			default:          lock_cfg.valid_card_uid = val;
		endcase
		@(negedge clk);
	endtask

	task automatic user_entry();
		int bad_at;
		if ($urandom_range(0, 7) == 0) begin
			tap(key_t'($urandom_range(0, 13)));
			tap(KEY_CLEAR);
		end
		if ($urandom_range(0, 9) == 0)
			repeat ($urandom_range(9, 12)) tap(key_t'($urandom_range(0, 13)));
		bad_at = ($urandom_range(0, 5) == 0) ? $urandom_range(0, CODE_MAX - 1) : -1;
		for (int i = 0; i < p_user_n; i++)
			tap(i == bad_at ? key_t'($urandom_range(0, 13)) : p_user[i]);
		tap(KEY_ENTER);
	endtask

	task automatic admin_walk();
		int bad_at;
		int pick;
		if (p_mode == LM_ADMIN_TRY) begin
			bad_at = ($urandom_range(0, 5) == 0) ? $urandom_range(0, CODE_MAX - 1) : -1;
			for (int i = 0; i < p_admin_n; i++)
				tap(i == bad_at ? key_t'($urandom_range(0, 13)) : p_admin[i]);
			tap(KEY_ENTER);
		end
		if (p_mode == LM_MENU) begin
			pick = $urandom_range(0, 99);
			tap(pick < 20 ? KEY_MENU_EXIT : pick < 50 ? KEY_SET_ADMIN :
				pick < 85 ? KEY_SET_USER : key_t'($urandom_range(3, 15)));
		end
		if (p_mode == LM_NEW_CODE) begin
			if ($urandom_range(0, 5) == 0) begin
				tap(key_t'($urandom_range(0, 13)));
				tap(KEY_CLEAR);
			end
			repeat ($urandom_range(0, 10)) tap(key_t'($urandom_range(0, 13)));
			tap(KEY_ENTER);
			if ($urandom_range(0, 9) < 7)
				tap(KEY_MENU_EXIT);
		end
	endtask

	task automatic random_sequence();
		int    pick;
		item_t it;
		pick = $urandom_range(0, 99);
		if (pick < 30) begin
			it = any_item(CMD_TICK);
			if ($urandom_range(0, 1) == 1 && lock_cfg.near_limit_cm > 1)
				it.distance_cm = DIST_W'($urandom_range(1, lock_cfg.near_limit_cm - 1));
			send(it);
		end else if (pick < 62) begin
			if (p_mode != LM_NORMAL)
				admin_walk();
			else
				user_entry();
		end else if (pick < 72) begin
			it = any_item(CMD_CARD);
			if ($urandom_range(0, 1) == 1)
				it.card_uid = lock_cfg.valid_card_uid;
			send(it);
		end else if (pick < 80) begin
			send(any_item(CMD_REMOTE));
		end else begin
			tap(key_t'($urandom_range(0, 15)));
		end
	endtask

	initial begin
		cfg_t phase_cfg;
		int   target;
		arst_n             = 1'b0;
		evt_ch.valid       = 1'b0;
		evt_ch.cmd         = CMD_TICK;
		evt_ch.distance_cm = '0;
		evt_ch.key_code    = '0;
		evt_ch.card_uid    = '0;
		evt_ch.remote_open = 1'b0;
		cfg_ch.valid       = 1'b0;
		cfg_ch.index       = CFG_OPEN_TICKS;
		cfg_ch.data        = '0;
		lock_cfg = '{RST_OPEN_TICKS, RST_ACTIVE_TICKS, RST_NEAR_LIMIT, RST_CARD_UID};
		p_mode        = LM_NORMAL;
		p_door        = 1'b0;
		p_active      = 1'b0;
		p_hold        = 1'b0;
		p_active_left = '0;
		p_open_left   = '0;
		p_pin_n       = 0;
		p_aux_n       = 0;
		p_target      = TGT_NONE;
		for (int i = 0; i < DEF_CODE_LEN; i++) begin
			p_user[i]  = DEF_USER_CODE[i];
			p_admin[i] = DEF_ADMIN_CODE[i];
		end
		p_user_n  = DEF_CODE_LEN;
		p_admin_n = DEF_CODE_LEN;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int r = 0; r < PLAN_LEN; r++)
			send_event(DOOR_PLAN[r].ev_in, DOOR_PLAN[r].typed, DOOR_PLAN[r].want);

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: phase_cfg = '{16'd1, 16'd1, 9'd1, 32'd0};
				1: phase_cfg = '{16'hFFFF, 16'hFFFF, 9'd511, 32'hFFFF_FFFF};
				2: phase_cfg = '{16'd6, 16'd12, 9'd300, RST_CARD_UID};
				3: phase_cfg = '{TIMER_W'($urandom_range(1, 40)),
					TIMER_W'($urandom_range(1, 60)), DIST_W'($urandom_range(2, 511)),
					$urandom};
				default: phase_cfg = '{RST_OPEN_TICKS, RST_ACTIVE_TICKS, RST_NEAR_LIMIT,
					$urandom};
			endcase
			drain();
			write_reg(CFG_OPEN_TICKS, CFG_DAT_W'(phase_cfg.open_ticks));
			write_reg(CFG_ACTIVE_TICKS, CFG_DAT_W'(phase_cfg.active_ticks));
			write_reg(CFG_NEAR_LIMIT, CFG_DAT_W'(phase_cfg.near_limit_cm));
			write_reg(CFG_CARD_UID, phase_cfg.valid_card_uid);
			cfg_ch.valid = 1'b0;
			tx_calm = ($urandom_range(0, 2) == 0);
			target = items_sent + PHASE_ITEMS;
			while (items_sent < target) begin
				random_sequence();
				if ($urandom_range(0, 39) == 0)
					drain();
			end
		end

		drain();
		repeat (8) @(posedge clk);
		if (bad_count == 0 && outcomes_due.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		int   stall;
		res_t got;
		res_t want;
		res_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = rx_calm ? 0 : $urandom_range(0, 19);
			if (stall != 0) begin
				res_ch.ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			res_ch.ready = 1'b1;
			do @(posedge clk); while (res_ch.valid !== 1'b1);
			got = '{res_ch.door_open, res_ch.lock_active, event_t'(res_ch.event_res),
				res_ch.entered_keys, res_ch.lock_mode};
			if (outcomes_due.size() == 0) begin
				bad_count++;
				if (bad_count <= 10)
					$display("result item with none expected: %p", got);
			end else begin
				want = outcomes_due.pop_front();
				if (got.door_open !== want.door_open || got.lock_active !== want.lock_active ||
						got.event_res !== want.event_res ||
						got.entered_keys !== want.entered_keys ||
						got.lock_mode !== want.lock_mode) begin
					bad_count++;
					if (bad_count <= 10)
						$display("result mismatch: expected %p, got %p", want, got);
				end
			end
			@(negedge clk);
			if ($urandom_range(0, 63) == 0)
				rx_calm = !rx_calm;
		end
	end

	always @(posedge clk) begin
		if ((evt_ch.valid === 1'b1 && evt_ch.ready === 1'b1) ||
				(res_ch.valid === 1'b1 && res_ch.ready === 1'b1) ||
				(cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == IDLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

endmodule

/* filelist.f */
hw/rtl/kcdl_pkg.sv
hw/rtl/kcdl_ifs.sv
hw/rtl/kcdl_core.sv
hw/rtl/kcdl_skid.sv
hw/rtl/keypad_card_door_lock_controller.sv
tb/tb_keypad_card_door_lock_controller.sv
